@@ rtl/core/tcphp_pkg.sv @@
// shared types and constants for the tcp header byte parser
package tcphp_pkg;

    localparam int unsigned POS_W = 6;
    localparam int unsigned LEFT_W = 6;

    localparam logic [POS_W-1:0] POS_PORTS_END = 6'd4;
    localparam logic [POS_W-1:0] POS_SEQACK_END = 6'd12;
    localparam logic [POS_W-1:0] POS_FLAGS_END = 6'd14;
    localparam logic [POS_W-1:0] FIXED_LEN = 6'd20;
    localparam logic [LEFT_W-1:0] FIXED_LEN_LEFT = 6'd20;

    localparam logic [7:0] OPT_KIND_MSS = 8'h02;
    localparam logic [3:0] MIN_OFFSET = 4'd5;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ZERO_FLAGS = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    typedef enum logic [3:0] {
        PH_KIND = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_HI   = 4'b0100,
        PH_LO   = 4'b1000
    } opt_phase_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       first_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [3:0]  data_offset;
        logic [11:0] flag_bits;
        logic [15:0] window_size;
        logic [15:0] header_checksum;
        logic [15:0] urgent_pointer;
        logic [15:0] max_segment_size;
        logic        has_options;
        logic [1:0]  status;
    } result_t;

    typedef struct packed {
        logic    emit;
        result_t result;
    } parse_out_t;

endpackage

@@ rtl/core/tcphp_in_reg.sv @@
// input register holding the next header byte request
module tcphp_in_reg
    import tcphp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic       advance,
    output logic       in_stall,
    output in_item_t   item
);

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       first_reg;

    assign in_stall = valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            data_reg  <= data_byte;
            first_reg <= first_byte;
        end
    end

    assign item = '{valid: valid_reg, data_byte: data_reg, first_byte: first_reg};

endmodule

@@ rtl/core/tcphp_parse.sv @@
// parse state and per-byte field assembly and option walk
module tcphp_parse
    import tcphp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   item,
    input  logic       advance,
    output parse_out_t pout
);

    logic [POS_W-1:0]  pos_reg;
    logic [LEFT_W-1:0] left_reg;
    opt_phase_t        phase_reg;
    logic              done_reg;
    logic [31:0]       ports_reg;
    logic [63:0]       seqack_reg;
    logic [15:0]       offflags_reg;
    logic [47:0]       wcu_reg;
    logic [15:0]       mss_reg;
    logic              seen_reg;

    logic [POS_W-1:0]  pos_next;
    logic [LEFT_W-1:0] left_next;
    opt_phase_t        phase_next;
    logic              done_next;
    logic [31:0]       ports_next;
    logic [63:0]       seqack_next;
    logic [15:0]       offflags_next;
    logic [47:0]       wcu_next;
    logic [15:0]       mss_next;
    logic              seen_next;
    logic              emit;
    logic [1:0]        status;

    always_comb
    begin
        pos_next      = pos_reg;
        left_next     = left_reg;
        phase_next    = phase_reg;
        done_next     = done_reg;
        ports_next    = ports_reg;
        seqack_next   = seqack_reg;
        offflags_next = offflags_reg;
        wcu_next      = wcu_reg;
        mss_next      = mss_reg;
        seen_next     = seen_reg;
        emit          = 1'b0;
        status        = ST_OK;

        if (item.valid && (item.first_byte || !done_reg))
        begin
            // restart clears everything
            if (item.first_byte)
            begin
                pos_next      = '0;
                left_next     = '0;
                phase_next    = PH_KIND;
                done_next     = 1'b0;
                ports_next    = '0;
                seqack_next   = '0;
                offflags_next = '0;
                wcu_next      = '0;
                mss_next      = '0;
                seen_next     = 1'b0;
            end

            if (pos_next < FIXED_LEN)
            begin
                if (pos_next < POS_PORTS_END)
                begin
                    ports_next = {ports_next[23:0], item.data_byte};
                end
                else if (pos_next < POS_SEQACK_END)
                begin
                    seqack_next = {seqack_next[55:0], item.data_byte};
                end
                else if (pos_next < POS_FLAGS_END)
                begin
                    offflags_next = {offflags_next[7:0], item.data_byte};
                end
                else
                begin
                    wcu_next = {wcu_next[39:0], item.data_byte};
                end
                pos_next = pos_next + 6'd1;

                if (pos_next == POS_FLAGS_END && offflags_next[11:0] == 12'd0)
                begin
                    emit   = 1'b1;
                    status = ST_ZERO_FLAGS;
                end
                else if (pos_next == FIXED_LEN)
                begin
                    if (offflags_next[15:12] < MIN_OFFSET)
                    begin
                        emit   = 1'b1;
                        status = ST_MALFORMED;
                    end
                    else if (offflags_next[15:12] == MIN_OFFSET)
                    begin
                        emit   = 1'b1;
                        status = ST_OK;
                    end
                    else
                    begin
                        left_next  = {offflags_next[15:12], 2'b00} - FIXED_LEN_LEFT;
                        phase_next = PH_KIND;
                    end
                end
            end
            else
            begin
                // option area
                left_next = left_next - 6'd1;
                seen_next = 1'b1;
                unique case (phase_next)
                    PH_KIND:
                    begin
                        if (item.data_byte != OPT_KIND_MSS)
                        begin
                            emit   = 1'b1;
                            status = ST_UNSUPPORTED;
                        end
                        else
                        begin
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        phase_next = PH_HI;
                    end
                    PH_HI:
                    begin
                        mss_next   = {mss_next[7:0], item.data_byte};
                        phase_next = PH_LO;
                    end
                    PH_LO:
                    begin
                        mss_next   = {mss_next[7:0], item.data_byte};
                        phase_next = PH_KIND;
                    end
                    default:
                    begin
                        phase_next = PH_KIND;
                    end
                endcase
                if (!emit && left_next == '0)
                begin
                    emit   = 1'b1;
                    status = (phase_next == PH_KIND) ? ST_OK : ST_MALFORMED;
                end
            end

            if (emit)
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            left_reg     <= '0;
            phase_reg    <= PH_KIND;
            done_reg     <= 1'b1;
            ports_reg    <= '0;
            seqack_reg   <= '0;
            offflags_reg <= '0;
            wcu_reg      <= '0;
            mss_reg      <= '0;
            seen_reg     <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg      <= pos_next;
            left_reg     <= left_next;
            phase_reg    <= phase_next;
            done_reg     <= done_next;
            ports_reg    <= ports_next;
            seqack_reg   <= seqack_next;
            offflags_reg <= offflags_next;
            wcu_reg      <= wcu_next;
            mss_reg      <= mss_next;
            seen_reg     <= seen_next;
        end
    end

    assign pout.emit                    = emit;
    assign pout.result.src_port         = ports_next[31:16];
    assign pout.result.dst_port         = ports_next[15:0];
    assign pout.result.seq_number       = seqack_next[63:32];
    assign pout.result.ack_number       = seqack_next[31:0];
    assign pout.result.data_offset      = offflags_next[15:12];
    assign pout.result.flag_bits        = offflags_next[11:0];
    assign pout.result.window_size      = wcu_next[47:32];
    assign pout.result.header_checksum  = wcu_next[31:16];
    assign pout.result.urgent_pointer   = wcu_next[15:0];
    assign pout.result.max_segment_size = mss_next;
    assign pout.result.has_options      = seen_next;
    assign pout.result.status           = status;

endmodule

@@ rtl/core/tcphp_out_reg.sv @@
// result register for the parsed header
module tcphp_out_reg
    import tcphp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result_in,
    input  logic    out_stall,
    output logic    out_valid,
    output result_t result_out
);

    logic    valid_reg;
    result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

@@ rtl/core/tcp_header_byte_parser_unit.sv @@
// tcp header byte parser top level
// Takes one TCP header byte per cycle while in_stall is low (first_byte restarts the
// parse) and gives one result request per header with a status, the last MSS option
// value and the fixed fields parsed so far: all of them, but for a zero-flags result,
// which ends at the flags. Each byte is held in the input register and is parsed on
// its way into the result register, which drives out_valid. Bytes that end no header
// keep flowing while a result is held by out_stall; only a byte that would end a
// header waits for the result register to empty.
module tcp_header_byte_parser_unit
    import tcphp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] src_port,
    output logic [15:0] dst_port,
    output logic [31:0] seq_number,
    output logic [31:0] ack_number,
    output logic [3:0]  data_offset,
    output logic [11:0] flag_bits,
    output logic [15:0] window_size,
    output logic [15:0] header_checksum,
    output logic [15:0] urgent_pointer,
    output logic [15:0] max_segment_size,
    output logic        has_options,
    output logic [1:0]  status
);

    in_item_t   item;
    parse_out_t pout;
    result_t    result;
    logic       advance;
    logic       out_load;

    // a byte that ends a header waits while the held result is stalled
    assign advance  = item.valid && !(out_valid && out_stall && pout.emit);
    assign out_load = advance && pout.emit;

    tcphp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .advance    (advance),
        .in_stall   (in_stall),
        .item       (item)
    );

    tcphp_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .advance (advance),
        .pout    (pout)
    );

    tcphp_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (out_load),
        .result_in  (pout.result),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .result_out (result)
    );

    assign src_port         = result.src_port;
    assign dst_port         = result.dst_port;
    assign seq_number       = result.seq_number;
    assign ack_number       = result.ack_number;
    assign data_offset      = result.data_offset;
    assign flag_bits        = result.flag_bits;
    assign window_size      = result.window_size;
    assign header_checksum  = result.header_checksum;
    assign urgent_pointer   = result.urgent_pointer;
    assign max_segment_size = result.max_segment_size;
    assign has_options      = result.has_options;
    assign status           = result.status;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_load && out_valid && out_stall))
        else $error("held result overwritten");

    a_plain_byte_flows: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && !pout.emit) |-> !in_stall)
        else $error("non-final byte stalled");

    a_zero_flags_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_ZERO_FLAGS) |->
        (flag_bits == 12'd0 && window_size == 16'd0 && has_options == 1'b0))
        else $error("zero-flag result carries late fields");

    a_ok_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OK) |-> (data_offset >= MIN_OFFSET))
        else $error("ok status with short data offset");
`endif

endmodule
